### hdl/vsrf_pkg.sv
package vsrf_pkg;

  // Window geometry
  localparam int WINDOW_DEPTH = 4;
  localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);
  localparam int IDX_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int VAL_W        = 8;
  localparam int SUM_W        = $clog2(WINDOW_DEPTH * 255 + WINDOW_DEPTH / 2 + 1);
  localparam int CNT_W        = (SUM_W > 1) ? $clog2(SUM_W) : 1;

  // Field widths
  localparam int RAW_W      = 11;
  localparam int VAR_W      = 18;
  localparam int HR_W       = 8;
  localparam int OX_W       = 7;
  localparam int HR_LIM_W   = 8;
  localparam int OX_LIM_W   = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HR_LIMIT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPO2_LIMIT = 1'd1;

  // Register reset values
  localparam logic [HR_LIM_W-1:0] HR_LIMIT_RST = 8'd15;
  localparam logic [OX_LIM_W-1:0] OX_LIMIT_RST = 7'd3;

  // Range limits
  localparam logic signed [RAW_W-1:0] HR_LOW      = 11'sd40;
  localparam logic signed [RAW_W-1:0] HR_HIGH     = 11'sd200;
  localparam logic signed [RAW_W-1:0] OX_ZERO     = 11'sd0;
  localparam logic signed [RAW_W-1:0] OX_CLAMP_LO = 11'sd65;   // raw at or below: 65
  localparam logic signed [RAW_W-1:0] OX_CLAMP_HI = 11'sd101;  // raw above: 100
  localparam logic [VAL_W-1:0]        OX_MIN      = 8'd65;
  localparam logic [VAL_W-1:0]        OX_MAX      = 8'd100;
  localparam logic [VAL_W-1:0]        HARM_RATE   = 8'd118;
  localparam logic [VAL_W-1:0]        HALF_LOW    = 8'd50;
  localparam logic [VAL_W-1:0]        HALF_HIGH   = 8'd100;
  localparam logic [VAR_W-1:0]        VAR_LOW     = 18'd600;
  localparam logic [VAR_W-1:0]        VAR_HIGH    = 18'd50000;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture item, start mean of stored window
    logic step;    // one divider step
    logic decide;  // outlier check, push, start mean of new window
    logic finish;  // move results to output register
  } cmd_t;

endpackage

### hdl/vital_sign_result_filter.sv
// Each input transfer runs the bit-serial divider for the rounded window mean
// twice, once before and once after the decide step, then hands off the result.
// No new item is taken until the result of the last one is handed to the output
// register; a stall that holds the output register delays that hand-off.
// Reset (rst_ni, async, active low): windows empty, outlier limits 15 and 3,
// output not valid; window contents are not cleared.
module vital_sign_result_filter (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [vsrf_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [vsrf_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [vsrf_pkg::RAW_W-1:0]    raw_heart_rate_i,
  input  logic                                 heart_rate_flag_i,
  input  logic signed [vsrf_pkg::RAW_W-1:0]    raw_oxygen_i,
  input  logic                                 oxygen_flag_i,
  input  logic [vsrf_pkg::VAR_W-1:0]           ir_variation_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [vsrf_pkg::HR_W-1:0]            heart_rate_o,
  output logic                                 heart_rate_ok_o,
  output logic [vsrf_pkg::OX_W-1:0]            oxygen_o,
  output logic                                 oxygen_ok_o
);

  vsrf_pkg::cmd_t                     cmd;
  logic                               out_free;
  logic [vsrf_pkg::HR_LIM_W-1:0]      hr_limit_q;
  logic [vsrf_pkg::OX_LIM_W-1:0]      ox_limit_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hr_limit_q <= vsrf_pkg::HR_LIMIT_RST;
      ox_limit_q <= vsrf_pkg::OX_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        vsrf_pkg::REG_HR_LIMIT:   hr_limit_q <= cfg_data_i[vsrf_pkg::HR_LIM_W-1:0];
        vsrf_pkg::REG_SPO2_LIMIT: ox_limit_q <= cfg_data_i[vsrf_pkg::OX_LIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  vsrf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_free_i (out_free),
    .cmd_o      (cmd)
  );

  vsrf_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .out_free_o        (out_free),
    .raw_heart_rate_i  (raw_heart_rate_i),
    .heart_rate_flag_i (heart_rate_flag_i),
    .raw_oxygen_i      (raw_oxygen_i),
    .oxygen_flag_i     (oxygen_flag_i),
    .ir_variation_i    (ir_variation_i),
    .hr_limit_i        (hr_limit_q),
    .ox_limit_i        (ox_limit_q),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .heart_rate_o      (heart_rate_o),
    .heart_rate_ok_o   (heart_rate_ok_o),
    .oxygen_o          (oxygen_o),
    .oxygen_ok_o       (oxygen_ok_o)
  );

endmodule

### hdl/vsrf_lane.sv
module vsrf_lane (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  vsrf_pkg::cmd_t              cmd_i,
  input  logic [vsrf_pkg::VAL_W-1:0]  x_i,
  input  logic                        ok_i,
  input  logic [vsrf_pkg::VAL_W-1:0]  limit_i,
  output logic [vsrf_pkg::VAL_W-1:0]  res_o,
  output logic                        ok_o
);

  logic [vsrf_pkg::VAL_W-1:0]  win_q [vsrf_pkg::WINDOW_DEPTH];
  logic [vsrf_pkg::FILL_W-1:0] fill_q, fill_d;
  logic [vsrf_pkg::SUM_W-1:0]  sum_q, sum_d;
  logic [vsrf_pkg::VAL_W-1:0]  x_q, mean_q;
  logic                        ok_q, pushed_q, push;
  logic                        full;

  // Divider state
  logic [vsrf_pkg::FILL_W-1:0] rem_q, rem_d, div_n_q;
  logic [vsrf_pkg::SUM_W-1:0]  quo_q, quo_d;
  logic [vsrf_pkg::FILL_W:0]   rem_sh;
  logic                        ge;

  logic [vsrf_pkg::VAL_W-1:0]  mean, diff;
  logic                        reject;

  assign full = (fill_q == vsrf_pkg::FILL_W'(vsrf_pkg::WINDOW_DEPTH));
  assign mean = quo_q[vsrf_pkg::VAL_W-1:0];
  assign diff = (x_q > mean) ? (x_q - mean) : (mean - x_q);

  // Outlier test once the window holds two or more entries
  assign reject = (fill_q >= vsrf_pkg::FILL_W'(2)) && (diff > limit_i);
  assign push   = ok_q && !reject;

  // Running sum and fill after a push
  always_comb begin
    sum_d  = sum_q;
    fill_d = fill_q;
    if (push) begin
      if (full) begin
        sum_d = sum_q + vsrf_pkg::SUM_W'(x_q) - vsrf_pkg::SUM_W'(win_q[0]);
      end else begin
        sum_d  = sum_q + vsrf_pkg::SUM_W'(x_q);
        fill_d = fill_q + vsrf_pkg::FILL_W'(1);
      end
    end
  end

  // Restoring divider step, one quotient bit per cycle
  assign rem_sh = {rem_q, quo_q[vsrf_pkg::SUM_W-1]};
  assign ge     = (rem_sh >= {1'b0, div_n_q});
  assign rem_d  = ge ? vsrf_pkg::FILL_W'(rem_sh - {1'b0, div_n_q})
                     : rem_sh[vsrf_pkg::FILL_W-1:0];
  assign quo_d  = {quo_q[vsrf_pkg::SUM_W-2:0], ge};

  // Control state of the lane
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      sum_q    <= '0;
      ok_q     <= 1'b0;
      pushed_q <= 1'b0;
    end else if (cmd_i.load) begin
      ok_q     <= ok_i;
      pushed_q <= 1'b0;
    end else if (cmd_i.decide) begin
      fill_q   <= fill_d;
      sum_q    <= sum_d;
      pushed_q <= push;
    end
  end

  // Item, mean and divider registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q     <= x_i;
      rem_q   <= '0;
      div_n_q <= fill_q;
      quo_q   <= sum_q + vsrf_pkg::SUM_W'(fill_q >> 1);
    end else if (cmd_i.decide) begin
      mean_q  <= mean;
      rem_q   <= '0;
      div_n_q <= fill_d;
      quo_q   <= sum_d + vsrf_pkg::SUM_W'(fill_d >> 1);
    end else if (cmd_i.step) begin
      rem_q   <= rem_d;
      quo_q   <= quo_d;
    end
  end

  // Window: fill from the bottom, shift once full
  always_ff @(posedge clk_i) begin
    if (cmd_i.decide && push) begin
      for (int i = 0; i < vsrf_pkg::WINDOW_DEPTH; i++) begin
        if (full) begin
          if (i == vsrf_pkg::WINDOW_DEPTH - 1) begin
            win_q[i] <= x_q;
          end else begin
            win_q[i] <= win_q[i+1];
          end
        end else if (fill_q == vsrf_pkg::FILL_W'(i)) begin
          win_q[i] <= x_q;
        end
      end
    end
  end

  // Result: zero when invalid, mean of old window when rejected
  assign res_o = !ok_q ? '0 : (pushed_q ? mean : mean_q);
  assign ok_o  = ok_q;

endmodule

### hdl/vsrf_datapath.sv
module vsrf_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  vsrf_pkg::cmd_t                    cmd_i,
  output logic                              out_free_o,
  input  logic signed [vsrf_pkg::RAW_W-1:0] raw_heart_rate_i,
  input  logic                              heart_rate_flag_i,
  input  logic signed [vsrf_pkg::RAW_W-1:0] raw_oxygen_i,
  input  logic                              oxygen_flag_i,
  input  logic [vsrf_pkg::VAR_W-1:0]        ir_variation_i,
  input  logic [vsrf_pkg::HR_LIM_W-1:0]     hr_limit_i,
  input  logic [vsrf_pkg::OX_LIM_W-1:0]     ox_limit_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [vsrf_pkg::HR_W-1:0]         heart_rate_o,
  output logic                              heart_rate_ok_o,
  output logic [vsrf_pkg::OX_W-1:0]         oxygen_o,
  output logic                              oxygen_ok_o
);

  logic                       hr_ok, ox_ok, harm;
  logic                       hr_lane_ok, ox_lane_ok;
  logic [vsrf_pkg::VAL_W-1:0] hr_raw8, hr_half, hr_val, ox_val, hr_res, ox_res;
  logic signed [vsrf_pkg::RAW_W-1:0] ox_dec;
  logic                       out_valid_q;
  logic [vsrf_pkg::HR_W-1:0]  hr_q;
  logic [vsrf_pkg::OX_W-1:0]  ox_q;
  logic                       hr_ok_q, ox_ok_q;

  // Heart rate range check and harmonic correction
  assign hr_ok   = heart_rate_flag_i && (raw_heart_rate_i >= vsrf_pkg::HR_LOW)
                   && (raw_heart_rate_i <= vsrf_pkg::HR_HIGH);
  assign hr_raw8 = raw_heart_rate_i[vsrf_pkg::VAL_W-1:0];
  assign hr_half = hr_raw8 >> 1;
  assign harm    = (hr_raw8 >= vsrf_pkg::HARM_RATE)
                   && (ir_variation_i >= vsrf_pkg::VAR_LOW)
                   && (ir_variation_i <= vsrf_pkg::VAR_HIGH)
                   && (hr_half >= vsrf_pkg::HALF_LOW)
                   && (hr_half <= vsrf_pkg::HALF_HIGH);
  assign hr_val  = harm ? hr_half : hr_raw8;

  // SpO2 offset and clamp
  assign ox_ok  = oxygen_flag_i && (raw_oxygen_i > vsrf_pkg::OX_ZERO);
  assign ox_dec = raw_oxygen_i - vsrf_pkg::RAW_W'(1);
  always_comb begin
    if (raw_oxygen_i <= vsrf_pkg::OX_CLAMP_LO) begin
      ox_val = vsrf_pkg::OX_MIN;
    end else if (raw_oxygen_i > vsrf_pkg::OX_CLAMP_HI) begin
      ox_val = vsrf_pkg::OX_MAX;
    end else begin
      ox_val = ox_dec[vsrf_pkg::VAL_W-1:0];
    end
  end

  vsrf_lane u_hr_lane (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_i),
    .x_i     (hr_val),
    .ok_i    (hr_ok),
    .limit_i (vsrf_pkg::VAL_W'(hr_limit_i)),
    .res_o   (hr_res),
    .ok_o    (hr_lane_ok)
  );

  vsrf_lane u_ox_lane (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_i),
    .x_i     (ox_val),
    .ok_i    (ox_ok),
    .limit_i (vsrf_pkg::VAL_W'(ox_limit_i)),
    .res_o   (ox_res),
    .ok_o    (ox_lane_ok)
  );

  // Output register
  assign out_free_o = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      hr_q    <= hr_res[vsrf_pkg::HR_W-1:0];
      ox_q    <= ox_res[vsrf_pkg::OX_W-1:0];
      hr_ok_q <= hr_lane_ok;
      ox_ok_q <= ox_lane_ok;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign heart_rate_o    = hr_q;
  assign heart_rate_ok_o = hr_ok_q;
  assign oxygen_o        = ox_q;
  assign oxygen_ok_o     = ox_ok_q;

endmodule

### hdl/vsrf_ctrl.sv
module vsrf_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic           out_free_i,
  output vsrf_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE,
    ST_DECIDE,
    ST_POST,
    ST_DONE
  } state_e;

  state_e                      state_q;
  logic [vsrf_pkg::CNT_W-1:0]  cnt_q;
  logic                        last;

  assign last = (cnt_q == vsrf_pkg::CNT_W'(vsrf_pkg::SUM_W - 1));

  // Command decode
  assign in_stall_o    = (state_q != ST_IDLE);
  assign cmd_o.load    = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.step    = (state_q == ST_PRE) || (state_q == ST_POST);
  assign cmd_o.decide  = (state_q == ST_DECIDE);
  assign cmd_o.finish  = (state_q == ST_DONE) && out_free_i;

  // Sequencer: mean of stored window, decide, mean of new window, hand off
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
          if (in_valid_i) begin
            state_q <= ST_PRE;
          end
        end
        ST_PRE: begin
          cnt_q <= cnt_q + vsrf_pkg::CNT_W'(1);
          if (last) begin
            state_q <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          cnt_q   <= '0;
          state_q <= ST_POST;
        end
        ST_POST: begin
          cnt_q <= cnt_q + vsrf_pkg::CNT_W'(1);
          if (last) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### verif/tb_vital_sign_result_filter.sv
module tb_vital_sign_result_filter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 170;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 40;

  typedef enum int {CH_RATE = 0, CH_OXY = 1} chan_e;

  // One raw estimate as offered to the filter
  typedef struct packed {
    logic signed [vsrf_pkg::RAW_W-1:0] raw_hr;
    logic                              hr_flag;
    logic signed [vsrf_pkg::RAW_W-1:0] raw_ox;
    logic                              ox_flag;
    logic [vsrf_pkg::VAR_W-1:0]        ir_var;
  } reading_t;

  // One filtered result
  typedef struct packed {
    logic [vsrf_pkg::HR_W-1:0] hr;
    logic                      hr_ok;
    logic [vsrf_pkg::OX_W-1:0] ox;
    logic                      ox_ok;
  } vitals_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                            cfg_we    = 1'b0;
  logic [vsrf_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [vsrf_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  logic                              in_valid    = 1'b0;
  logic                              in_stall;
  logic signed [vsrf_pkg::RAW_W-1:0] raw_hr_drv  = '0;
  logic                              hr_flag_drv = 1'b0;
  logic signed [vsrf_pkg::RAW_W-1:0] raw_ox_drv  = '0;
  logic                              ox_flag_drv = 1'b0;
  logic [vsrf_pkg::VAR_W-1:0]        ir_var_drv  = '0;

  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [vsrf_pkg::HR_W-1:0] heart_rate;
  logic                      heart_rate_ok;
  logic [vsrf_pkg::OX_W-1:0] oxygen;
  logic                      oxygen_ok;

  // Filter state mirrored by the predictor
  logic [7:0] win [2][vsrf_pkg::WINDOW_DEPTH];
  int         fill_of  [2];
  int         limit_of [2];

  reading_t pending_readings[$];
  vitals_t  vitals_due[$];
  reading_t on_offer;

  int send_gap     = 0;
  int stall_left   = 0;
  int in_idle_pct  = 0;
  int out_idle_pct = 0;
  logic hold_on    = 1'b0;

  int hr_center = 80;
  int ox_center = 97;

  int queued_count   = 0;
  int taken_count    = 0;
  int checked_count  = 0;
  int held_count     = 0;
  int halved_count   = 0;
  int settings_count = 0;
  int error_count    = 0;
  int cycle_count    = 0;

  int in_pcts  [PHASES] = '{0, 25, 50, 10, 0, 70, 25, 5};
  int out_pcts [PHASES] = '{0, 10, 25, 60, 40, 0, 80, 25};

  logic [vsrf_pkg::CFG_DATA_W-1:0] hr_lim_v;
  logic [vsrf_pkg::CFG_DATA_W-1:0] ox_lim_v;

  vital_sign_result_filter DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .raw_heart_rate_i  (raw_hr_drv),
    .heart_rate_flag_i (hr_flag_drv),
    .raw_oxygen_i      (raw_ox_drv),
    .oxygen_flag_i     (ox_flag_drv),
    .ir_variation_i    (ir_var_drv),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .heart_rate_o      (heart_rate),
    .heart_rate_ok_o   (heart_rate_ok),
    .oxygen_o          (oxygen),
    .oxygen_ok_o       (oxygen_ok)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what);
    error_count++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // Rounded mean of the first n held entries
  function automatic int window_avg(chan_e ch, int n);
    int sum;
    sum = 0;
    for (int i = 0; i < n; i++) sum += win[ch][i];
    return (sum + n / 2) / n;
  endfunction

  // Outlier rejection, then push into the sliding window
  function automatic int smooth_into(chan_e ch, int x);
    int n;
    int avg;
    int dev;
    n = fill_of[ch];
    if (n >= 2) begin
      avg = window_avg(ch, n);
      dev = (x > avg) ? x - avg : avg - x;
      if (dev > limit_of[ch]) begin
        held_count++;
        return avg;
      end
    end
    if (n < vsrf_pkg::WINDOW_DEPTH) begin
      win[ch][n] = 8'(x);
      n++;
    end else begin
      for (int i = 1; i < vsrf_pkg::WINDOW_DEPTH; i++) win[ch][i-1] = win[ch][i];
      win[ch][vsrf_pkg::WINDOW_DEPTH-1] = 8'(x);
    end
    fill_of[ch] = n;
    return window_avg(ch, n);
  endfunction

  // Range checks, harmonic correction, SpO2 clamp and smoothing
  function automatic vitals_t filter_reading(reading_t r);
    vitals_t v;
    int hr;
    int ox;
    int rate;
    int ir;
    v  = '0;
    hr = int'(r.raw_hr);
    ox = int'(r.raw_ox);
    ir = int'(r.ir_var);
    if (r.hr_flag && hr >= int'(vsrf_pkg::HR_LOW) && hr <= int'(vsrf_pkg::HR_HIGH)) begin
      rate = hr;
      if (rate >= int'(vsrf_pkg::HARM_RATE) && ir >= int'(vsrf_pkg::VAR_LOW) &&
          ir <= int'(vsrf_pkg::VAR_HIGH) && rate / 2 >= int'(vsrf_pkg::HALF_LOW) &&
          rate / 2 <= int'(vsrf_pkg::HALF_HIGH)) begin
        rate = rate / 2;
        halved_count++;
      end
      v.hr_ok = 1'b1;
      v.hr    = vsrf_pkg::HR_W'(smooth_into(CH_RATE, rate));
    end
    if (r.ox_flag && ox > 0) begin
      ox = ox - 1;
      if (ox < int'(vsrf_pkg::OX_MIN)) ox = int'(vsrf_pkg::OX_MIN);
      if (ox > int'(vsrf_pkg::OX_MAX)) ox = int'(vsrf_pkg::OX_MAX);
      v.ox_ok = 1'b1;
      v.ox    = vsrf_pkg::OX_W'(smooth_into(CH_OXY, ox));
    end
    return v;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap(int pct);
    if (int'($urandom_range(0, 99)) >= pct) return 0;
    if ($urandom_range(0, 99) < 85) return int'($urandom_range(1, 3));
    return int'($urandom_range(10, 60));
  endfunction

  function automatic reading_t mk(int hr, logic hf, int ox, logic of, int ir);
    reading_t r;
    r.raw_hr  = vsrf_pkg::RAW_W'(hr);
    r.hr_flag = hf;
    r.raw_ox  = vsrf_pkg::RAW_W'(ox);
    r.ox_flag = of;
    r.ir_var  = vsrf_pkg::VAR_W'(ir);
    return r;
  endfunction

  // Mostly plausible readings around a drifting center, some edges, some noise
  function automatic reading_t gen_reading();
    reading_t r;
    int sel;
    int hr;
    int ox;
    int pick;
    int hr_edge [10] = '{-1024, 0, 39, 40, 41, 117, 118, 119, 200, 201};
    int ox_edge [11] = '{-1024, -1, 0, 1, 2, 65, 66, 100, 101, 102, 1023};
    int ir_edge [6]  = '{0, 599, 600, 50000, 50001, 262143};
    sel       = int'($urandom_range(0, 99));
    r.raw_hr  = vsrf_pkg::RAW_W'($urandom);
    r.hr_flag = 1'($urandom_range(0, 1));
    r.raw_ox  = vsrf_pkg::RAW_W'($urandom);
    r.ox_flag = 1'($urandom_range(0, 1));
    r.ir_var  = vsrf_pkg::VAR_W'($urandom);
    if (sel < 78) begin
      hr = hr_center + int'($urandom_range(0, 16)) - 8;
      if ($urandom_range(0, 9) == 0)
        hr += ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(20, 90));
      ox = ox_center + int'($urandom_range(0, 6)) - 3;
      if ($urandom_range(0, 9) == 0)
        ox += ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(4, 30));
      r.raw_hr  = vsrf_pkg::RAW_W'(hr);
      r.raw_ox  = vsrf_pkg::RAW_W'(ox);
      r.hr_flag = ($urandom_range(0, 15) != 0);
      r.ox_flag = ($urandom_range(0, 15) != 0);
      pick = int'($urandom_range(0, 9));
      if (pick < 7) r.ir_var = vsrf_pkg::VAR_W'($urandom_range(600, 50000));
      else if (pick == 7) r.ir_var = vsrf_pkg::VAR_W'($urandom_range(0, 599));
      else r.ir_var = vsrf_pkg::VAR_W'($urandom_range(50001, 262143));
    end else if (sel < 90) begin
      r.raw_hr = vsrf_pkg::RAW_W'(hr_edge[$urandom_range(0, 9)]);
      r.raw_ox = vsrf_pkg::RAW_W'(ox_edge[$urandom_range(0, 10)]);
      r.ir_var = vsrf_pkg::VAR_W'(ir_edge[$urandom_range(0, 5)]);
    end
    return r;
  endfunction

  task automatic queue_reading(input reading_t r);
    pending_readings.push_back(r);
    queued_count++;
  endtask

  // Block until every queued reading went in and its result came back
  task automatic wait_drained();
    while (taken_count != queued_count || vitals_due.size() != 0) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [vsrf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [vsrf_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == vsrf_pkg::REG_HR_LIMIT)
      limit_of[CH_RATE] = int'(vsrf_pkg::HR_LIM_W'(val));
    else if (idx == vsrf_pkg::REG_SPO2_LIMIT)
      limit_of[CH_OXY] = int'(vsrf_pkg::OX_LIM_W'(val));
  endtask

  // Input driver: predicts on each transfer, then offers the next reading
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        vitals_due.push_back(filter_reading(on_offer));
        taken_count++;
      end
      if (in_valid && in_stall) begin
        // stalled transfer keeps its payload
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_readings.size() != 0) begin
        on_offer    = pending_readings.pop_front();
        raw_hr_drv  <= on_offer.raw_hr;
        hr_flag_drv <= on_offer.hr_flag;
        raw_ox_drv  <= on_offer.raw_ox;
        ox_flag_drv <= on_offer.ox_flag;
        ir_var_drv  <= on_offer.ir_var;
        in_valid    <= 1'b1;
        send_gap    = pick_gap(in_idle_pct);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output monitor: compares each transfer with the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    vitals_t want;
    int g;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (vitals_due.size() == 0) begin
          flag_mismatch("result with no estimate pending");
        end else begin
          want = vitals_due.pop_front();
          checked_count++;
          if (heart_rate !== want.hr)
            flag_mismatch($sformatf("heart_rate %0d, expected %0d", heart_rate, want.hr));
          if (heart_rate_ok !== want.hr_ok)
            flag_mismatch($sformatf("heart_rate_ok %0b, expected %0b",
                                    heart_rate_ok, want.hr_ok));
          if (oxygen !== want.ox)
            flag_mismatch($sformatf("oxygen %0d, expected %0d", oxygen, want.ox));
          if (oxygen_ok !== want.ox_ok)
            flag_mismatch($sformatf("oxygen_ok %0b, expected %0b", oxygen_ok, want.ox_ok));
        end
      end
      if (hold_on) begin
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        g = pick_gap(out_idle_pct);
        if (g > 0) begin
          stall_left = g - 1;
          out_stall  <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  // Stimulus sequence
  initial begin
    fill_of[CH_RATE]  = 0;
    fill_of[CH_OXY]   = 0;
    limit_of[CH_RATE] = int'(vsrf_pkg::HR_LIMIT_RST);
    limit_of[CH_OXY]  = int'(vsrf_pkg::OX_LIMIT_RST);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: field extremes, range edges, harmonic band edges, clamps, flags
    queue_reading(mk(-1024, 1'b1, -1024, 1'b1, 0));
    queue_reading(mk(1023, 1'b1, 1023, 1'b1, 262143));
    queue_reading(mk(0, 1'b1, 0, 1'b1, 600));
    queue_reading(mk(39, 1'b1, 1, 1'b1, 600));
    queue_reading(mk(40, 1'b1, 65, 1'b1, 599));
    queue_reading(mk(41, 1'b1, 66, 1'b1, 0));
    queue_reading(mk(200, 1'b1, 100, 1'b1, 100));
    queue_reading(mk(201, 1'b1, 101, 1'b1, 0));
    queue_reading(mk(118, 1'b1, 102, 1'b1, 600));
    queue_reading(mk(117, 1'b0, 70, 1'b0, 600));
    queue_reading(mk(50, 1'b1, -1, 1'b1, 50000));
    queue_reading(mk(100, 1'b1, 99, 1'b1, 50001));
    queue_reading(mk(118, 1'b1, 98, 1'b1, 50000));
    queue_reading(mk(120, 1'b1, 97, 1'b1, 600));
    queue_reading(mk(200, 1'b1, 2, 1'b1, 49999));
    queue_reading(mk(66, 1'b1, 98, 1'b1, 262143));
    queue_reading(mk(60, 1'b1, 99, 1'b1, 1000));
    queue_reading(mk(-1, 1'b1, 98, 1'b0, 50001));
    queue_reading(mk(62, 1'b0, 97, 1'b1, 1000));
    queue_reading(mk(180, 1'b1, 96, 1'b1, 1000));
    queue_reading(mk(64, 1'b1, 40, 1'b1, 1000));
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin hr_lim_v = 8'd0;   ox_lim_v = 8'd0;   end
        1: begin hr_lim_v = 8'd255; ox_lim_v = 8'hFF;  end
        2: begin hr_lim_v = 8'd15;  ox_lim_v = 8'd3;   end
        3: begin
          hr_lim_v = vsrf_pkg::CFG_DATA_W'($urandom_range(2, 30));
          ox_lim_v = vsrf_pkg::CFG_DATA_W'($urandom_range(0, 8));
        end
        4: begin hr_lim_v = 8'd5;   ox_lim_v = 8'd1;   end
        5: begin
          hr_lim_v = vsrf_pkg::CFG_DATA_W'($urandom_range(0, 255));
          ox_lim_v = vsrf_pkg::CFG_DATA_W'($urandom_range(0, 255));
        end
        6: begin hr_lim_v = 8'd200; ox_lim_v = 8'd127; end
        default: begin hr_lim_v = 8'd1; ox_lim_v = 8'd0; end
      endcase
      cfg_write(vsrf_pkg::REG_HR_LIMIT, hr_lim_v);
      cfg_write(vsrf_pkg::REG_SPO2_LIMIT, ox_lim_v);
      settings_count++;
      in_idle_pct  = in_pcts[ph];
      out_idle_pct = out_pcts[ph];
      @(negedge clk_i);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 40 == 0) begin
          hr_center = int'($urandom_range(40, 200));
          ox_center = int'($urandom_range(60, 104));
        end
        queue_reading(gen_reading());
      end
      wait_drained();

      // Long receiver hold-off while the sender keeps offering
      if (ph == 3) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
        @(posedge clk_i);
        hold_on <= 1'b1;
        fork
          begin
            repeat (HOLD_CYCLES) @(posedge clk_i);
            hold_on <= 1'b0;
          end
        join_none
        @(negedge clk_i);
        for (int k = 0; k < 30; k++) queue_reading(gen_reading());
        wait_drained();
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("covered %0d estimates under %0d outlier limit settings, %0d results checked",
             taken_count, settings_count, checked_count);
    $display("%0d values held back as outliers, %0d heart rates halved",
             held_count, halved_count);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
